/* hdl/lru_replacement_policy_assert.svh */
// assertion macros for the lru replacement policy
// expects clk_i and rst_ni in the scope of the including module
`ifndef LRU_REPLACEMENT_POLICY_ASSERT_SVH
`define LRU_REPLACEMENT_POLICY_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru replacement policy check failed");

// next-cycle implication, checked outside reset
`define LRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru replacement policy check failed");

`endif

/* hdl/lrp_pkg.sv */
// shared types and constants of the lru replacement policy
// no dependencies
`default_nettype none

package lrp_pkg;

  localparam int MASK_W   = 16;
  localparam int INDEX_W  = 4;

  localparam logic OP_ACCESS  = 1'b0;
  localparam logic OP_REPLACE = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [INDEX_W-1:0] block_index;
    logic [MASK_W-1:0]  valid_mask;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] victim_index;
    logic               victim_was_free;
  } out_word_t;

  // control broadcast to every cell of the recency chain
  typedef struct packed {
    logic upd;    // commit the shift this cycle
    logic touch;  // access: cell holding blk_i starts the shift
    logic evict;  // replace with all valid: head cell starts the shift
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/lrp_cell.sv */
// one position of the recency chain, holding a single block index
// depends on lrp_pkg
`default_nettype none

module lrp_cell #(
  parameter int IdxW     = 4,
  parameter int ResetVal = 0,
  parameter bit IsHead   = 1'b0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lrp_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [IdxW-1:0]   blk_i,
  input  wire logic [IdxW-1:0]   nxt_val_i,
  input  wire logic              shift_i,
  output logic                   shift_o,
  output logic [IdxW-1:0]        val_o
);

  logic [IdxW-1:0] val_q, val_d;
  logic            hit;

  assign hit     = (ctrl_i.touch && (val_q == blk_i)) || (ctrl_i.evict && IsHead);
  assign shift_o = shift_i | hit;
  assign val_o   = val_q;

  // from the moved entry onwards every cell takes its neighbour's value
  always_comb begin
    val_d = val_q;
    if (ctrl_i.upd && shift_o) begin
      val_d = nxt_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= IdxW'(ResetVal);
    end else begin
      val_q <= val_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/lru_replacement_policy.sv */
// lru replacement policy for a fully associative set of NUM_BLOCKS blocks. a word is
// accepted into a work register and retires from it; a replace writes its result into
// the output register as it retires, and can only retire while that register is free or
// emptying. a new word is taken in the cycle the previous one retires, giving up to one
// word per cycle when the output is not stalled. the recency list is a chain of
// NUM_BLOCKS cells, least recent at cell 0. an
// access finds its block by a compare in every cell, and that cell plus all cells above it
// take the value of their upper neighbour while the last cell takes the touched block. a
// replace returns the lowest invalid block (blocks 16 and up count as invalid) without
// touching the list, or, with every block valid, the head of the list, which is then rotated
// to the most-recent end. accesses give no result word; accesses to a missing block are
// ignored. after reset the list holds NUM_BLOCKS-1 down to 0, least recent first.
// depends on lrp_pkg, lrp_cell and lru_replacement_policy_assert.svh
`default_nettype none

`include "lru_replacement_policy_assert.svh"

module lru_replacement_policy #(
  parameter int NUM_BLOCKS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire lrp_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lrp_pkg::out_word_t     out_word_o
);

  localparam int IdxW = $clog2(NUM_BLOCKS);

  // work register, holds the word being retired
  logic              busy_q, busy_d;
  lrp_pkg::in_word_t work_q;
  logic              in_acc;
  logic              done;

  // output register
  logic               out_valid_q, out_valid_d;
  lrp_pkg::out_word_t out_word_q;

  // recency chain
  logic [IdxW-1:0]     cell_val [NUM_BLOCKS];
  logic [NUM_BLOCKS:0] shift;
  logic [IdxW-1:0]     moved_val;
  lrp_pkg::cell_ctrl_t ctrl;

  // decode of the word under work
  logic [IdxW+lrp_pkg::INDEX_W-1:0] blk_ext;
  logic [IdxW-1:0]                  blk;
  logic                             blk_in_range;
  logic [NUM_BLOCKS-1:0]            blk_valid;
  logic                             all_valid;
  logic [IdxW-1:0]                  free_idx;
  logic [IdxW+lrp_pkg::INDEX_W-1:0] victim_ext;
  logic                             is_replace;

  // a replace can only retire when the output register is free or emptying
  assign is_replace = (work_q.operation == lrp_pkg::OP_REPLACE);
  assign done       = busy_q && (!is_replace || !out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q && !done;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d = busy_q;
    if (in_acc) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      work_q <= in_word_i;
    end
  end

  // block index widened or narrowed to the chain width
  assign blk_ext      = (IdxW + lrp_pkg::INDEX_W)'(work_q.block_index);
  assign blk          = blk_ext[IdxW-1:0];
  assign blk_in_range = (int'(work_q.block_index) < NUM_BLOCKS);

  // blocks beyond the mask have no bit and count as invalid
  always_comb begin
    blk_valid = '0;
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      if (k < lrp_pkg::MASK_W) begin
        blk_valid[k] = work_q.valid_mask[4'(k)];
      end
    end
  end

  assign all_valid = &blk_valid;

  // lowest invalid block, scanned from the top so the lowest wins
  always_comb begin
    free_idx = '0;
    for (int k = NUM_BLOCKS - 1; k >= 0; k--) begin
      if (!blk_valid[k]) begin
        free_idx = IdxW'(k);
      end
    end
  end

  // chain control
  assign ctrl.upd   = done;
  assign ctrl.touch = !is_replace && blk_in_range;
  assign ctrl.evict = is_replace && all_valid;
  assign moved_val  = ctrl.evict ? cell_val[0] : blk;
  assign shift[0]   = 1'b0;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    logic [IdxW-1:0] nxt_val;
    if (g == NUM_BLOCKS - 1) begin : g_tail
      // most-recent end takes the moved block
      assign nxt_val = moved_val;
    end else begin : g_body
      assign nxt_val = cell_val[g+1];
    end

    lrp_cell #(
      .IdxW     (IdxW),
      .ResetVal (NUM_BLOCKS - 1 - g),
      .IsHead   (g == 0)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .blk_i     (blk),
      .nxt_val_i (nxt_val),
      .shift_i   (shift[g]),
      .shift_o   (shift[g+1]),
      .val_o     (cell_val[g])
    );
  end

  // victim reported in its low four bits
  assign victim_ext = all_valid ? (IdxW + lrp_pkg::INDEX_W)'(cell_val[0])
                                : (IdxW + lrp_pkg::INDEX_W)'(free_idx);

  always_comb begin
    out_valid_d = out_valid_q;
    if (done && is_replace) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && is_replace) begin
      out_word_q.victim_index    <= victim_ext[lrp_pkg::INDEX_W-1:0];
      out_word_q.victim_was_free <= !all_valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // every block index sits in exactly one cell
  logic [(1<<IdxW)-1:0] present;
  always_comb begin
    present = '0;
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      present[cell_val[k]] = 1'b1;
    end
  end

  `LRP_ASSERT_NOW(a_list_is_permutation, 1'b1, &present[NUM_BLOCKS-1:0])
  `LRP_ASSERT_NOW(a_stall_only_when_busy, in_stall_o, busy_q)
  `LRP_ASSERT_NEXT(a_result_from_replace, done && is_replace, out_valid_o)
  `LRP_ASSERT_NEXT(a_no_result_from_access, done && !is_replace && !(out_valid_q && out_stall_i),
                   !out_valid_o)

endmodule

`default_nettype wire
